// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker
// each macro expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/tsom_pkg.sv -----
`timescale 1ns / 1ps
// shared types and constants for the three-stack memory block
// no dependencies
package tsom_pkg;

  localparam int MEM_DEPTH  = 128;
  localparam int WORD_BITS  = 32;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SIZE_W     = 8;
  localparam int DATA_W     = 32;

  localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(128);

  // divide by three on an 8-bit value: (x * 171) >> 9
  localparam int RECIP3     = 171;
  localparam int RECIP3_SH  = 9;

  localparam logic       FUNC_PUSH = 1'b0;
  localparam logic       FUNC_POP  = 1'b1;

  localparam logic [1:0] SEL_FIRST  = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    CS_IDLE,
    CS_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic exec;
    logic cfg_write;
  } dp_cmd_t;

endpackage

// ----- rtl/tsom_ctrl.sv -----
`timescale 1ns / 1ps
// controller: accepts commands and config writes, sequences the result strobe
// depends on tsom_pkg
module tsom_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              cfg_valid,
  output logic              busy,
  output logic              cfg_ready,
  output logic              done,
  output tsom_pkg::dp_cmd_t cmd
);
  import tsom_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    busy          = 1'b0;
    cfg_ready     = 1'b0;
    done          = 1'b0;
    cmd.exec      = 1'b0;
    cmd.cfg_write = 1'b0;
    unique case (state)
      CS_IDLE: begin
        // a command takes the cycle, a size write waits until start drops
        cfg_ready     = !start;
        cmd.cfg_write = cfg_valid && !start;
        if (start) begin
          cmd.exec   = 1'b1;
          state_next = CS_RESP;
        end
      end
      CS_RESP: begin
        busy       = 1'b1;
        done       = 1'b1;
        state_next = CS_IDLE;
      end
      default: begin
        state_next = CS_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/tsom_datapath.sv -----
`timescale 1ns / 1ps
// datapath: size register, region split, fill counters, stack memory, result registers
// depends on tsom_pkg
module tsom_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  tsom_pkg::dp_cmd_t             cmd,
  input  logic [tsom_pkg::SIZE_W-1:0]   total_size,
  input  logic                          func,
  input  logic [1:0]                    stack_select,
  input  logic signed [tsom_pkg::DATA_W-1:0] push_value,
  output logic signed [tsom_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                    status,
  output logic                          now_empty,
  output logic                          now_full,
  output logic [tsom_pkg::SIZE_W-1:0]   region_size
);
  import tsom_pkg::*;

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];

  logic [SIZE_W-1:0] size_reg;
  logic [SIZE_W-1:0] fill_first;
  logic [SIZE_W-1:0] fill_second;
  logic [SIZE_W-1:0] fill_third;

  logic [WORD_BITS-1:0] rd_data;
  logic                 res_popped;
  status_t              res_status;
  logic                 res_empty;
  logic                 res_full;
  logic [SIZE_W-1:0]    res_region;

  logic [SIZE_W-1:0]   used;
  logic [2*SIZE_W-1:0] prod;
  logic [SIZE_W-1:0]   s1;
  logic [SIZE_W-1:0]   s3;
  logic [SIZE_W-1:0]   region;
  logic [SIZE_W-1:0]   fill_cur;
  logic [SIZE_W-1:0]   fill_new;
  logic [SIZE_W-1:0]   offset;
  logic [SIZE_W:0]     addr_wide;
  logic [ADDR_W-1:0]   addr;
  logic                push_ok;
  logic                pop_ok;
  status_t             step_status;

  always_comb begin
    used = (32'(size_reg) > MEM_DEPTH) ? SIZE_W'(MEM_DEPTH) : size_reg;
    prod = (2*SIZE_W)'(used) * (2*SIZE_W)'(RECIP3);
    s1   = SIZE_W'(prod >> RECIP3_SH);
    s3   = used - SIZE_W'({1'b0, s1} << 1);

    if (stack_select == SEL_FIRST) begin
      region   = s1;
      fill_cur = fill_first;
    end else if (stack_select == SEL_SECOND) begin
      region   = s1;
      fill_cur = fill_second;
    end else begin
      region   = s3;
      fill_cur = fill_third;
    end

    push_ok     = (func == FUNC_PUSH) && (fill_cur < region);
    pop_ok      = (func == FUNC_POP) && (fill_cur != '0);
    fill_new    = fill_cur;
    step_status = ST_DONE;
    if (func == FUNC_PUSH) begin
      if (push_ok) begin
        fill_new = fill_cur + SIZE_W'(1);
      end else begin
        step_status = ST_FULL;
      end
    end else begin
      if (pop_ok) begin
        fill_new = fill_cur - SIZE_W'(1);
      end else begin
        step_status = ST_EMPTY;
      end
    end

    // a pop addresses the entry below the current fill
    offset = (func == FUNC_POP) ? fill_cur - SIZE_W'(1) : fill_cur;
    if (stack_select == SEL_FIRST) begin
      addr_wide = {1'b0, s1} - (SIZE_W+1)'(1) - {1'b0, offset};
    end else if (stack_select == SEL_SECOND) begin
      addr_wide = {1'b0, s1} + {1'b0, offset};
    end else begin
      addr_wide = ({1'b0, s1} << 1) + {1'b0, offset};
    end
    addr = ADDR_W'(addr_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg    <= RESET_SIZE;
      fill_first  <= '0;
      fill_second <= '0;
      fill_third  <= '0;
    end else if (cmd.cfg_write) begin
      size_reg    <= total_size;
      fill_first  <= '0;
      fill_second <= '0;
      fill_third  <= '0;
    end else if (cmd.exec) begin
      if (stack_select == SEL_FIRST) begin
        fill_first <= fill_new;
      end else if (stack_select == SEL_SECOND) begin
        fill_second <= fill_new;
      end else begin
        fill_third <= fill_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok) begin
      mem[addr] <= WORD_BITS'($unsigned(push_value));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && pop_ok) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_popped <= pop_ok;
      res_status <= step_status;
      res_empty  <= (fill_new == '0);
      res_full   <= (fill_new >= region);
      res_region <= region;
    end
  end

  assign pop_value   = res_popped ? DATA_W'(rd_data) : '0;
  assign status      = res_status;
  assign now_empty   = res_empty;
  assign now_full    = res_full;
  assign region_size = res_region;

endmodule

// ----- rtl/three_stacks_one_memory_core.sv -----
`timescale 1ns / 1ps
// top level: three stacks sharing one memory, controller plus datapath
// depends on tsom_pkg, tsom_ctrl, tsom_datapath
//
// channel   handshake             payload
// command   start / busy          func, stack_select, push_value
// result    done (one-cycle)      pop_value, status, now_empty, now_full, region_size
// config    cfg_valid / cfg_ready total_size
//
// each command runs its step at the accept edge (at most one memory access and one
// fill counter update), and the result shows with done the next cycle
// busy is high during the result cycle, so no new command is taken until it ends
// reset sets the size to 128 and empties all stacks; memory contents are not cleared
// the receiver cannot stall; a size write also empties all stacks
module three_stacks_one_memory_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func,
  input  logic [1:0]                         stack_select,
  input  logic signed [tsom_pkg::DATA_W-1:0] push_value,
  output logic                               done,
  output logic signed [tsom_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                         status,
  output logic                               now_empty,
  output logic                               now_full,
  output logic [tsom_pkg::SIZE_W-1:0]        region_size,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tsom_pkg::SIZE_W-1:0]        total_size
);
  import tsom_pkg::*;

  dp_cmd_t cmd;

  tsom_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done),
    .cmd       (cmd)
  );

  tsom_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .total_size   (total_size),
    .func         (func),
    .stack_select (stack_select),
    .push_value   (push_value),
    .pop_value    (pop_value),
    .status       (status),
    .now_empty    (now_empty),
    .now_full     (now_full),
    .region_size  (region_size)
  );

endmodule

// ----- rtl/tsom_checker.sv -----
`timescale 1ns / 1ps
// port-level checker for three_stacks_one_memory_core, bound to the top level
// depends on tsom_pkg and assert_macros.svh
`include "assert_macros.svh"

module tsom_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               start,
  input logic                               busy,
  input logic                               done,
  input logic signed [tsom_pkg::DATA_W-1:0] pop_value,
  input logic [1:0]                         status,
  input logic                               now_empty,
  input logic                               now_full,
  input logic [tsom_pkg::SIZE_W-1:0]        region_size
);
  import tsom_pkg::*;

  // every accepted command gives its result in the next cycle
  `ASSERT_NEXT(a_result_follows, start && !busy, done)

  // no two results back to back
  `ASSERT_NEXT(a_single_strobe, done, !done)

  // a refused push means the stack is full
  `ASSERT_IMPL(a_refused_push, done && (status == ST_FULL), now_full)

  // a refused pop returns zero from an empty stack
  `ASSERT_IMPL(a_refused_pop, done && (status == ST_EMPTY), now_empty && (pop_value == '0))

  // a zero-size region is both empty and full
  `ASSERT_IMPL(a_zero_region, done && (region_size == '0), now_empty && now_full)

endmodule

bind three_stacks_one_memory_core tsom_checker u_tsom_checker (.*);

// ----- tb/sv/three_stacks_one_memory_core_tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for three_stacks_one_memory_core: directed table, then random push/pop
// phases over several sizes, each result compared with its pinned row or a shadow of the three stacks
// depends on tsom_pkg and three_stacks_one_memory_core
module three_stacks_one_memory_core_tb;
  import tsom_pkg::*;

  localparam logic [1:0] SEL_THIRD = 2'd2;
  localparam logic [1:0] SEL_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic [1:0]        status;
    logic              now_empty;
    logic              now_full;
    logic [SIZE_W-1:0] region_size;
  } stack_result_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [1:0]        sel;
    logic [DATA_W-1:0] word;
    logic              pinned;
    stack_result_t     want;
  } stim_row_t;

  localparam stack_result_t NO_WANT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = FUNC_PUSH;
  logic [1:0] stack_select = SEL_FIRST;
  logic signed [DATA_W-1:0] push_value = '0;
  logic cfg_valid = 1'b0;
  logic [SIZE_W-1:0] total_size = '0;
  logic busy, done, now_empty, now_full, cfg_ready;
  logic signed [DATA_W-1:0] pop_value;
  logic [1:0] status;
  logic [SIZE_W-1:0] region_size;

  // typed expectation travelling with a directed command
  logic pin_valid = 1'b0;
  stack_result_t pin_want = '0;

  logic [DATA_W-1:0] shadow_mem [MEM_DEPTH];
  int unsigned shadow_fill [3];
  logic [SIZE_W-1:0] shadow_size;
  stack_result_t pending_results [$];
  stim_row_t dir_rows [$];
  int fail_count = 0;
  int stall_cycles = 0;

  three_stacks_one_memory_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .stack_select(stack_select), .push_value(push_value), .done(done),
    .pop_value(pop_value), .status(status), .now_empty(now_empty), .now_full(now_full),
    .region_size(region_size), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .total_size(total_size)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic stack_result_t predict_stack_op(logic op, logic [1:0] sel,
                                                     logic [DATA_W-1:0] word);
    int unsigned used, s1, region, slot, idx, addr;
    bit moves;
    stack_result_t res;
    used = (shadow_size > MEM_DEPTH) ? MEM_DEPTH : shadow_size;
    s1 = used / 3;
    slot = (sel == SEL_FIRST) ? 0 : (sel == SEL_SECOND) ? 1 : 2;
    region = (slot == 2) ? used - 2 * s1 : s1;
    res = '0;
    res.status = ST_DONE;
    res.region_size = region[SIZE_W-1:0];
    moves = 1'b0;
    idx = 0;
    if (op == FUNC_PUSH) begin
      if (shadow_fill[slot] >= region) res.status = ST_FULL;
      else begin
        moves = 1'b1;
        idx = shadow_fill[slot];
      end
    end else begin
      if (shadow_fill[slot] == 0) res.status = ST_EMPTY;
      else begin
        moves = 1'b1;
        idx = shadow_fill[slot] - 1;
      end
    end
    if (moves) begin
      // stack one grows down from the top of its region, the others grow up
      case (slot)
        0: addr = s1 - 1 - idx;
        1: addr = s1 + idx;
        default: addr = 2 * s1 + idx;
      endcase
      if (op == FUNC_PUSH) begin
        shadow_mem[addr] = word;
        shadow_fill[slot] = shadow_fill[slot] + 1;
      end else begin
        res.pop_value = shadow_mem[addr];
        shadow_fill[slot] = shadow_fill[slot] - 1;
      end
    end
    res.now_empty = (shadow_fill[slot] == 0);
    res.now_full = (shadow_fill[slot] >= region);
    return res;
  endfunction

  // transfers on all three channels, result check and stall watchdog
  always @(posedge clk) begin
    stack_result_t got, want;
    bit moved;
    if (rst) begin
      shadow_size = RESET_SIZE;
      shadow_fill = '{0, 0, 0};
    end else begin
      moved = 1'b0;
      if (done !== 1'b0) begin
        moved = 1'b1;
        got = '{pop_value, status, now_empty, now_full, region_size};
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= PRINT_LIMIT)
            $display("%0t: result with nothing expected: %h", $time, got);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= PRINT_LIMIT)
              $display("%0t: expected pop %h st %0d e %b f %b sz %0d, got pop %h st %0d e %b f %b sz %0d",
                       $time, want.pop_value, want.status, want.now_empty, want.now_full,
                       want.region_size, got.pop_value, got.status, got.now_empty,
                       got.now_full, got.region_size);
          end
        end
      end
      if (start && busy === 1'b0) begin
        moved = 1'b1;
        want = predict_stack_op(func, stack_select, push_value);
        pending_results.push_back(pin_valid ? pin_want : want);
      end
      if (cfg_valid && cfg_ready === 1'b1) begin
        moved = 1'b1;
        shadow_size = total_size;
        shadow_fill = '{0, 0, 0};
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("three_stacks_one_memory_core regression: fail");
        $finish;
      end
    end
  end

  task automatic send_op(logic op, logic [1:0] sel, logic [DATA_W-1:0] word,
                         logic pinned, stack_result_t want);
    start <= 1'b1;
    func <= op;
    stack_select <= sel;
    push_value <= word;
    pin_valid <= pinned;
    pin_want <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic idle_gap(bit allowed);
    if (allowed && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // only written with the block idle; a write also empties the stacks
  task automatic write_size(logic [SIZE_W-1:0] size);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2 + $urandom_range(0, 3)) @(posedge clk);
    cfg_valid <= 1'b1;
    total_size <= size;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] phase_sizes [10];
    int push_pct, focus;
    logic op;
    logic [1:0] sel;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] corner_words [4];

    corner_words = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

    // reset size 128: regions of 42, 42 and 44
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_FIRST, 0, 1, '{0, ST_EMPTY, 1, 0, 42}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_SECOND, 0, 1, '{0, ST_EMPTY, 1, 0, 42}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_THIRD, 0, 1, '{0, ST_EMPTY, 1, 0, 44}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_SPARE, 0, 1, '{0, ST_EMPTY, 1, 0, 44}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_FIRST, 32'h7FFF_FFFF, 1,
                         '{0, ST_DONE, 0, 0, 42}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_SECOND, 32'h8000_0000, 1,
                         '{0, ST_DONE, 0, 0, 42}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_THIRD, 32'hFFFF_FFFF, 1,
                         '{0, ST_DONE, 0, 0, 44}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_SPARE, 0, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_THIRD, 32'h5555_AAAA, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_SPARE, 0, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_FIRST, 0, 1,
                         '{32'h7FFF_FFFF, ST_DONE, 1, 0, 42}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_SECOND, 0, 1,
                         '{32'h8000_0000, ST_DONE, 1, 0, 42}});
    // size zero: every region is empty and full at once
    dir_rows.push_back('{ROW_CFG, FUNC_PUSH, SEL_FIRST, 0, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_FIRST, 5, 1, '{0, ST_FULL, 1, 1, 0}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_THIRD, 0, 1, '{0, ST_EMPTY, 1, 1, 0}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_SPARE, 7, 1, '{0, ST_FULL, 1, 1, 0}});
    // size 4: regions of 1, 1 and 2
    dir_rows.push_back('{ROW_CFG, FUNC_PUSH, SEL_FIRST, 4, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_FIRST, 32'h1234_5678, 1,
                         '{0, ST_DONE, 0, 1, 1}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_FIRST, 9, 1, '{0, ST_FULL, 0, 1, 1}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_SECOND, 32'hA5A5_A5A5, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_THIRD, 32'h0F0F_0F0F, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_THIRD, 32'hF0F0_F0F0, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_SPARE, 3, 1, '{0, ST_FULL, 0, 1, 2}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_FIRST, 0, 1,
                         '{32'h1234_5678, ST_DONE, 1, 0, 1}});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_SPARE, 0, 0, NO_WANT});
    // size beyond the memory depth acts as the full depth
    dir_rows.push_back('{ROW_CFG, FUNC_PUSH, SEL_FIRST, 255, 0, NO_WANT});
    dir_rows.push_back('{ROW_CMD, FUNC_POP, SEL_THIRD, 0, 1, '{0, ST_EMPTY, 1, 0, 44}});
    dir_rows.push_back('{ROW_CMD, FUNC_PUSH, SEL_SECOND, 32'hDEAD_0001, 0, NO_WANT});

    phase_sizes = '{8'd128, 8'd5, 8'd0, 8'd255, 8'd1, 8'd2, 8'd14, 8'd130, 8'd9,
                    SIZE_W'($urandom_range(0, 255))};

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) write_size(dir_rows[r].word[SIZE_W-1:0]);
      else begin
        idle_gap(1'b1);
        send_op(dir_rows[r].op, dir_rows[r].sel, dir_rows[r].word, dir_rows[r].pinned,
                dir_rows[r].want);
      end
    end

    // each phase fills mostly one stack, then drains; phases 3 and 4 send commands with no idle gaps
    for (int phase = 0; phase < 10; phase++) begin
      write_size(phase_sizes[phase]);
      focus = $urandom_range(0, 2);
      for (int i = 0; i < 110; i++) begin
        push_pct = (i < 66) ? 95 : 30;
        op = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        sel = ($urandom_range(0, 99) < 85) ? focus[1:0] : 2'($urandom_range(0, 3));
        word = ($urandom_range(0, 7) == 0) ? corner_words[$urandom_range(0, 3)] : $urandom;
        idle_gap(phase != 3 && phase != 4);
        send_op(op, sel, word, 1'b0, NO_WANT);
      end
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("three_stacks_one_memory_core regression: pass");
    else
      $display("three_stacks_one_memory_core regression: fail");
    $finish;
  end

endmodule
